>>> design/cbmi_pkg.sv
// Shared types and constants of the cartridge bank mapper with scanline IRQ.
// Used by cbmi_mod.sv and cartridge_bank_mapper_irq_unit.sv; no dependencies.
package cbmi_pkg;

	// Operand widths of the shared remainder unit.
	localparam int DvdW     = 9;   // bank value before reduction, at most 255
	localparam int DivW     = 11;  // CHR 1K page count, up to 8 * 255
	localparam int ModSteps = DvdW;
	localparam int CntW     = $clog2(ModSteps);

	// Item kinds.
	localparam logic [1:0] ActWrite  = 2'd0;
	localparam logic [1:0] ActTick   = 2'd1;
	localparam logic [1:0] ActLookup = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CfgPrgUnits  = 2'd0;
	localparam logic [1:0] CfgChrUnits  = 2'd1;
	localparam logic [1:0] CfgFourScrn  = 2'd2;

	// CPU write decode.
	localparam logic [15:0] AddrMask     = 16'hE001;
	localparam logic [15:0] AddrSelect   = 16'h8000;
	localparam logic [15:0] AddrBankData = 16'hA000;
	localparam logic [15:0] AddrMirror   = 16'h8001;
	localparam logic [15:0] AddrIrqCount = 16'hC000;
	localparam logic [15:0] AddrIrqLatch = 16'hC001;
	localparam logic [15:0] AddrIrqOff   = 16'hE000;
	localparam logic [15:0] AddrIrqOn    = 16'hE001;

	// Bank-data targets picked by select register bits 2..0.
	localparam logic [2:0] TgtPrgA    = 3'd0;
	localparam logic [2:0] TgtPrgB    = 3'd1;
	localparam logic [2:0] TgtChrLow  = 3'd2;
	localparam logic [2:0] TgtChrHigh = 3'd3;

	localparam int SelPrgSwapBit = 6;
	localparam int SelChrSwapBit = 7;

	localparam logic [7:0] ChrPairMask   = 8'hFE;
	localparam logic [8:0] LastVisible   = 9'd239;

	typedef enum logic [1:0] {
		StIdle,
		StExec,
		StMod,
		StResp
	} cbmi_state_t;

endpackage

>>> design/cbmi_mod.sv
// Shared iterative remainder unit: one restoring shift-subtract step per cycle.
// Depends on cbmi_pkg.sv.
module cbmi_mod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic [cbmi_pkg::DvdW-1:0]   dividend,
	input  logic [cbmi_pkg::DivW-1:0]   divisor,
	output logic                        done,
	output logic [cbmi_pkg::DvdW-1:0]   remainder
);

	logic                        run_q;
	logic                        done_q;
	logic [cbmi_pkg::CntW-1:0]   cnt_q;
	logic [cbmi_pkg::DvdW-1:0]   dvd_q;
	logic [cbmi_pkg::DivW-1:0]   div_q;
	logic [cbmi_pkg::DivW-1:0]   rem_q;
	logic [cbmi_pkg::DivW:0]     trial;
	logic [cbmi_pkg::DivW:0]     diff;
	logic [cbmi_pkg::DivW-1:0]   rem_next;

	// The partial remainder stays below the divisor, so one compare and
	// subtract per dividend bit keeps it reduced.
	always_comb begin
		trial = {rem_q, dvd_q[cbmi_pkg::DvdW-1]};
		diff  = trial - {1'b0, div_q};
		if (trial >= {1'b0, div_q}) begin
			rem_next = diff[cbmi_pkg::DivW-1:0];
		end else begin
			rem_next = trial[cbmi_pkg::DivW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				run_q <= 1'b1;
				cnt_q <= cbmi_pkg::CntW'(cbmi_pkg::ModSteps - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - cbmi_pkg::CntW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[cbmi_pkg::DvdW-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q[cbmi_pkg::DvdW-1:0];

endmodule

>>> design/cartridge_bank_mapper_irq_unit.sv
// Top level of the cartridge bank mapper with scanline IRQ counter.
// Depends on cbmi_pkg.sv and cbmi_mod.sv.
//
// Usage: an item is taken at a rising edge where start is high and busy is
// low. action selects a CPU write (address, data), a scanline tick
// (scanline, rendering_on) or a bank lookup (window). Every item returns one
// result beat: done is high for exactly one cycle while bank, from_rom,
// mirroring_vertical and irq_request hold the result. The receiver cannot
// stall; the beat is taken at the edge that ends the done cycle.
// Writes, ticks and direct lookups (fixed last pages, PRG windows with a zero
// page count, CHR RAM windows, out-of-range windows) go from the execute
// state straight to the result state. Lookups that reduce a bank register
// modulo the ROM page count go through the shared remainder unit, nine
// shift-subtract steps, between the two. One item is in flight at a time;
// busy stays high until the done cycle has ended. Configuration (cfg_we, cfg_index,
// cfg_data) is written with no handshake; the user must see that it is only
// changed while the block is idle, which the block does not enforce. Reset
// loads the power-on bank layout, horizontal mirroring and a disabled IRQ counter.
module cartridge_bank_mapper_irq_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [15:0] address,
	input  logic [7:0]  data,
	input  logic [8:0]  scanline,
	input  logic        rendering_on,
	input  logic [3:0]  window,
	output logic        done,
	output logic [8:0]  bank,
	output logic        from_rom,
	output logic        mirroring_vertical,
	output logic        irq_request
);

	cbmi_pkg::cbmi_state_t state_q, state_next;

	// Configuration registers.
	logic [7:0] prg_units_q;
	logic [7:0] chr_units_q;
	logic       four_screen_q;

	// Captured item.
	logic [1:0]  action_q;
	logic [15:0] address_q;
	logic [7:0]  data_q;
	logic [8:0]  scanline_q;
	logic        rendering_q;
	logic [3:0]  window_q;

	// Mapper state.
	logic [7:0] select_q;
	logic [7:0] prg_a_q;
	logic [7:0] prg_b_q;
	logic [7:0] chr_low_q;
	logic [7:0] chr_high_q;
	logic [7:0] chr_single_q [4];
	logic       irq_en_q;
	logic [7:0] irq_cnt_q;
	logic [7:0] irq_latch_q;
	logic       mirror_q;

	// Result registers.
	logic [8:0] bank_q;
	logic       rom_q;
	logic       irq_q;

	logic accept;
	logic chr_ok;
	logic tick_live;

	// Lookup decode.
	logic [8:0]  prg_n;
	logic [10:0] chr_n;
	logic [2:0]  chr_c;
	logic [2:0]  chr_sw;
	logic [8:0]  chr_v;
	logic        use_mod;
	logic [8:0]  direct_bank;
	logic        direct_rom;
	logic [cbmi_pkg::DvdW-1:0] mod_dvd;
	logic [cbmi_pkg::DivW-1:0] mod_div;
	logic        mod_load;
	logic        mod_done;
	logic [cbmi_pkg::DvdW-1:0] mod_rem;

	assign accept    = start && !busy;
	assign chr_ok    = chr_units_q != 8'd0;
	assign tick_live = irq_en_q && (scanline_q <= cbmi_pkg::LastVisible) && rendering_q;

	// Work out the bank for a lookup: either a direct value or a register
	// that still has to be reduced modulo the page count.
	always_comb begin
		prg_n       = {prg_units_q, 1'b0};
		chr_n       = {chr_units_q, 3'b000};
		chr_c       = window_q[2:0] ^ 3'b100;
		chr_sw      = chr_c ^ {select_q[cbmi_pkg::SelChrSwapBit], 2'b00};
		use_mod     = 1'b0;
		direct_bank = '0;
		direct_rom  = 1'b0;
		mod_dvd     = '0;
		mod_div     = '0;
		case (chr_sw)
			3'd0:    chr_v = {1'b0, chr_low_q};
			3'd1:    chr_v = {1'b0, chr_low_q} + 9'd1;
			3'd2:    chr_v = {1'b0, chr_high_q};
			3'd3:    chr_v = {1'b0, chr_high_q} + 9'd1;
			default: chr_v = {1'b0, chr_single_q[chr_sw[1:0]]};
		endcase
		if (window_q < 4'd4) begin
			direct_rom = 1'b1;
			mod_div    = {2'b00, prg_n};
			if (prg_n != 9'd0) begin
				// Window order with PRG swap: second-last, B, A, last.
				case ({select_q[cbmi_pkg::SelPrgSwapBit], window_q[1:0]})
					3'b000, 3'b110: begin
						use_mod = 1'b1;
						mod_dvd = {1'b0, prg_a_q};
					end
					3'b001, 3'b101: begin
						use_mod = 1'b1;
						mod_dvd = {1'b0, prg_b_q};
					end
					3'b010, 3'b100: direct_bank = prg_n - 9'd2;
					default:        direct_bank = prg_n - 9'd1;
				endcase
			end
		end else if (window_q < 4'd12) begin
			if (chr_ok) begin
				use_mod    = 1'b1;
				mod_dvd    = chr_v;
				mod_div    = chr_n;
				direct_rom = 1'b1;
			end else begin
				// Character RAM: the 1K page of the window itself.
				direct_bank = {6'd0, chr_c};
			end
		end
	end

	assign mod_load = (state_q == cbmi_pkg::StExec) && (action_q == cbmi_pkg::ActLookup)
		&& use_mod;

	cbmi_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (mod_load),
		.dividend  (mod_dvd),
		.divisor   (mod_div),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	// Sequencer: capture, execute, optional reduction, one result cycle.
	always_comb begin
		state_next = state_q;
		case (state_q)
			cbmi_pkg::StIdle: if (accept) state_next = cbmi_pkg::StExec;
			cbmi_pkg::StExec: state_next = mod_load ? cbmi_pkg::StMod : cbmi_pkg::StResp;
			cbmi_pkg::StMod:  if (mod_done) state_next = cbmi_pkg::StResp;
			cbmi_pkg::StResp: state_next = cbmi_pkg::StIdle;
			default:          state_next = cbmi_pkg::StIdle;
		endcase
	end

	always_comb begin
		busy = state_q != cbmi_pkg::StIdle;
		done = state_q == cbmi_pkg::StResp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbmi_pkg::StIdle;
		end else begin
			state_q <= state_next;
		end
	end

	// Configuration writes; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_units_q   <= 8'd2;
			chr_units_q   <= 8'd1;
			four_screen_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				cbmi_pkg::CfgPrgUnits: prg_units_q   <= cfg_data;
				cbmi_pkg::CfgChrUnits: chr_units_q   <= cfg_data;
				cbmi_pkg::CfgFourScrn: four_screen_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q    <= action;
			address_q   <= address;
			data_q      <= data;
			scanline_q  <= scanline;
			rendering_q <= rendering_on;
			window_q    <= window;
		end
	end

	// Mapper state updates happen in the execute cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_q        <= 8'd0;
			prg_a_q         <= 8'd0;
			prg_b_q         <= 8'd1;
			chr_low_q       <= 8'd0;
			chr_high_q      <= 8'd2;
			chr_single_q[0] <= 8'd4;
			chr_single_q[1] <= 8'd5;
			chr_single_q[2] <= 8'd6;
			chr_single_q[3] <= 8'd7;
			irq_en_q        <= 1'b0;
			irq_cnt_q       <= 8'd0;
			irq_latch_q     <= 8'd0;
			mirror_q        <= 1'b0;
		end else if (state_q == cbmi_pkg::StExec) begin
			if (action_q == cbmi_pkg::ActWrite) begin
				case (address_q & cbmi_pkg::AddrMask)
					cbmi_pkg::AddrSelect: select_q <= data_q;
					cbmi_pkg::AddrBankData: begin
						case (select_q[2:0])
							cbmi_pkg::TgtPrgA: prg_a_q <= data_q;
							cbmi_pkg::TgtPrgB: prg_b_q <= data_q;
							cbmi_pkg::TgtChrLow: begin
								if (chr_ok) chr_low_q <= data_q & cbmi_pkg::ChrPairMask;
							end
							cbmi_pkg::TgtChrHigh: begin
								if (chr_ok) chr_high_q <= data_q & cbmi_pkg::ChrPairMask;
							end
							default: begin
								if (chr_ok) chr_single_q[select_q[1:0]] <= data_q;
							end
						endcase
					end
					cbmi_pkg::AddrMirror: if (!four_screen_q) mirror_q <= data_q[0];
					cbmi_pkg::AddrIrqCount: irq_cnt_q <= data_q;
					cbmi_pkg::AddrIrqLatch: irq_latch_q <= data_q;
					cbmi_pkg::AddrIrqOff: begin
						irq_en_q <= 1'b0;
						mirror_q <= data_q == 8'd0;
					end
					cbmi_pkg::AddrIrqOn: irq_en_q <= 1'b1;
					default: ;
				endcase
			end else if (action_q == cbmi_pkg::ActTick && tick_live) begin
				if (irq_cnt_q == 8'd0) begin
					irq_cnt_q <= irq_latch_q;
				end else begin
					irq_cnt_q <= irq_cnt_q - 8'd1;
				end
			end
		end
	end

	// Result registers: filled in the execute cycle, the bank again when
	// the remainder unit finishes.
	always_ff @(posedge clk) begin
		if (state_q == cbmi_pkg::StExec) begin
			bank_q <= '0;
			rom_q  <= 1'b0;
			irq_q  <= 1'b0;
			if (action_q == cbmi_pkg::ActLookup) begin
				bank_q <= direct_bank;
				rom_q  <= direct_rom;
			end else if (action_q == cbmi_pkg::ActTick) begin
				irq_q <= tick_live && (irq_cnt_q == 8'd0);
			end
		end else if (state_q == cbmi_pkg::StMod && mod_done) begin
			bank_q <= mod_rem;
		end
	end

	assign bank               = bank_q;
	assign from_rom           = rom_q;
	assign mirroring_vertical = mirror_q;
	assign irq_request        = irq_q;

	// A result beat lasts one cycle and returns the block to idle.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");

	// Work only starts from an accepted item.
	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a start");

	// The remainder unit only reports while the sequencer waits for it.
	a_mod_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> state_q == cbmi_pkg::StMod)
		else $error("remainder finished outside the wait state");

	// An IRQ pulse only comes from a tick item.
	a_irq_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		done && irq_request |-> action_q == cbmi_pkg::ActTick)
		else $error("IRQ request on a non-tick result");

endmodule
